// File: sv/scd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

  // Framing defaults
  localparam int DEF_MAX_DATA_BYTES = 8;
  localparam int TRAILER_BYTES      = 2;

  // Fixed result layout: eight payload slots whatever the data limit
  localparam int NUM_PAYLOAD = 8;
  localparam int OUT_BITS    = 16 + 4 + 8 * NUM_PAYLOAD;
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

  // Configuration register map
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SECOND = 2'd1;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'hFF;
  localparam logic [7:0] HEADER_SECOND_RST = 8'hFE;

  // Start marker bytes
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } hdr_cfg_t;

  // One recovered frame
  typedef struct packed {
    logic [NUM_PAYLOAD-1:0][7:0] payload;
    logic [3:0]                  data_len;
    logic [15:0]                 frame_id;
  } frame_t;

endpackage

`default_nettype wire

// File: sv/scd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module scd_parser
  import scd_pkg::*;
#(
  parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  hdr_cfg_t   hdr,
  output logic       emit,
  output frame_t     result
);

  localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  typedef enum logic [6:0] {
    ST_HUNT_A = 7'b0000001,
    ST_HUNT_B = 7'b0000010,
    ST_ID_HI  = 7'b0000100,
    ST_ID_LO  = 7'b0001000,
    ST_LEN    = 7'b0010000,
    ST_DATA   = 7'b0100000,
    ST_TRAIL  = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic [3:0]  count, count_next, count_inc;
  logic [15:0] id_hold, id_next;
  logic [3:0]  len_hold, len_next;
  logic        store_wr;
  logic        data_done;
  logic [7:0]  store [MAX_DATA_BYTES];
  logic [NUM_PAYLOAD-1:0][7:0] pay_out;

  // Byte-by-byte frame walk
  always_comb begin
    state_next = state;
    count_next = count;
    id_next    = id_hold;
    len_next   = len_hold;
    count_inc  = count + 4'd1;
    store_wr   = 1'b0;
    data_done  = 1'b0;
    emit       = 1'b0;
    if (in_fire) begin
      unique case (state)
        ST_HUNT_A: begin
          if (in_byte == hdr.first) state_next = ST_HUNT_B;
        end
        ST_HUNT_B: begin
          // a repeated first marker byte keeps waiting for the second
          if (in_byte == hdr.second) state_next = ST_ID_HI;
          else if (in_byte != hdr.first) state_next = ST_HUNT_A;
        end
        ST_ID_HI: begin
          id_next    = {in_byte, 8'h00};
          state_next = ST_ID_LO;
        end
        ST_ID_LO: begin
          id_next    = {id_hold[15:8], in_byte};
          state_next = ST_LEN;
        end
        ST_LEN: begin
          count_next = '0;
          if (in_byte > 8'(MAX_DATA_BYTES)) begin
            // oversized length: drop the frame
            state_next = ST_HUNT_A;
          end else begin
            len_next = in_byte[3:0];
            if (in_byte[3:0] == 4'd0) data_done = 1'b1;
            else state_next = ST_DATA;
          end
        end
        ST_DATA: begin
          store_wr   = 1'b1;
          count_next = count_inc;
          if (count_inc >= len_hold) data_done = 1'b1;
        end
        ST_TRAIL: begin
          count_next = count_inc;
          if (count_inc >= 4'(TRAILER_BYTES)) begin
            emit       = 1'b1;
            state_next = ST_HUNT_A;
            count_next = '0;
          end
        end
        default: begin
          state_next = ST_HUNT_A;
          count_next = '0;
        end
      endcase

      // end of data: go to the trailer, or finish straight away without one
      if (data_done) begin
        count_next = '0;
        if (TRAILER_BYTES == 0) begin
          emit       = 1'b1;
          state_next = ST_HUNT_A;
        end else begin
          state_next = ST_TRAIL;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_HUNT_A;
      count    <= '0;
      id_hold  <= '0;
      len_hold <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      id_hold  <= id_next;
      len_hold <= len_next;
    end
  end

  // Payload store
  always_ff @(posedge clk) begin
    if (store_wr) store[count[IDX_W-1:0]] <= in_byte;
  end

  // Result payload: the byte arriving now bypasses the store
  for (genvar k = 0; k < NUM_PAYLOAD; k++) begin : g_pay
    if (k < MAX_DATA_BYTES) begin : g_used
      assign pay_out[k] = (4'(k) < len_next)
                        ? ((store_wr && (count[IDX_W-1:0] == IDX_W'(k))) ? in_byte : store[k])
                        : 8'h00;
    end else begin : g_unused
      assign pay_out[k] = 8'h00;
    end
  end

  assign result = '{payload: pay_out, data_len: len_next, frame_id: id_hold};

  // Checks
  a_emit_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    emit |=> state == ST_HUNT_A)
    else $error("frame completion did not return to hunting");

  a_len_in_range: assert property (@(posedge clk) disable iff (rst)
    emit |-> result.data_len <= 4'(MAX_DATA_BYTES))
    else $error("frame length above data limit");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DATA |-> count < len_hold)
    else $error("data count reached length while still in data phase");

endmodule

`default_nettype wire

// File: sv/serial_can_frame_deframer.sv
// A result is offered on m_tvalid in the cycle after the byte that completes the frame.
// Throughput: one byte per cycle; the single output register lets a byte in while its
// held result is taken in the same cycle, so only a stalled output holds up s_tready.
// Reset (rst, synchronous, active high) returns to hunting for the start marker,
// empties the output register and loads the marker bytes FF and FE.
`timescale 1ns / 1ps
`default_nettype none

module serial_can_frame_deframer
  import scd_pkg::*;
#(
  parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  // input byte stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] data_byte
  // frame stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_W-1:0]       m_tdata,   // [15:0] frame_id, [19:16] data_len,
                                            // [27:20] payload0 .. [83:76] payload7, pad
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  hdr_cfg_t         hdr;
  logic             in_fire;
  logic             emit;
  frame_t           result;
  logic             out_valid;
  logic [OUT_W-1:0] out_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr.first  <= HEADER_FIRST_RST;
      hdr.second <= HEADER_SECOND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  hdr.first  <= cfg_data;
        CFG_HEADER_SECOND: hdr.second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input request taken whenever the output slot is free or draining
  assign s_tready = !out_valid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  scd_parser #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_byte (s_tdata),
    .hdr     (hdr),
    .emit    (emit),
    .result  (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data <= {(OUT_W - OUT_BITS)'(0), result};
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |-> !in_fire)
    else $error("byte accepted while result held and stalled");

  a_emit_offered: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("completed frame not offered");

  a_emit_needs_input: assert property (@(posedge clk) disable iff (rst)
    emit |-> in_fire)
    else $error("frame completed without an accepted byte");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import scd_pkg::*;

  localparam int STUCK_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int SEG_BYTES     = 75;
  localparam int SEG_FRAMES    = 5;
  localparam int NUM_SEGS      = 6;
  localparam int DIR_N         = 30;

  // Register indexes outside the map: writes to these must be ignored
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    GET_ID_HI,
    GET_ID_LO,
    GET_LEN,
    GET_DATA,
    SKIP_TRAILER
  } deframe_phase_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_INDEX_W-1:0]     idx;
    logic [7:0]                 val;
    logic                       typed;
    logic [15:0]                exp_id;
    logic [3:0]                 exp_len;
    logic [8*NUM_PAYLOAD-1:0]   exp_payload;
  } dir_row_t;

  // Directed stimulus; typed rows carry the frame that their byte completes
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // full-length frame, id 0000, extreme data bytes
    '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'hFE, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h00, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h00, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h08, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h00, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h80, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h7F, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h01, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'hFE, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'hAA, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h55, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h00, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'hFF, 1'b1, 16'h0000, 4'd8, 64'h55AA_FE01_7F80_00FF},
    // repeated first marker, id FFFF, zero length: all payload slots read zero
    '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'hFE, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h00, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'hAA, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h55, 1'b1, 16'hFFFF, 4'd0, 64'h0},
    // length one above the limit: frame dropped, back to hunting
    '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'hFE, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h12, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h34, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_BYTE, 2'd0, 8'h09, 1'b0, 16'h0000, 4'd0, 64'h0},
    // writes beyond the map; low index bit would alias onto the markers
    '{ROW_CFG, CFG_SPARE_A, 8'h5A, 1'b0, 16'h0000, 4'd0, 64'h0},
    '{ROW_CFG, CFG_SPARE_B, 8'hA5, 1'b0, 16'h0000, 4'd0, 64'h0}
  };

  // DUT ports
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata   = 8'h00;  // [7:0] data_byte
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_W-1:0]       m_tdata;            // [15:0] frame_id, [19:16] data_len,
                                              // [27:20] payload0 .. [83:76] payload7, pad
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data  = 8'h00;

  // Deframer mirror: marker bytes and frame assembly state
  logic [7:0]     hdr_first;
  logic [7:0]     hdr_second;
  deframe_phase_t ph;
  logic [3:0]     cnt;
  logic [15:0]    id_acc;
  logic [3:0]     len_acc;
  logic [7:0]     store [NUM_PAYLOAD];

  frame_t frame_q [$];

  int snd_idle = 9;
  int rcv_idle = 49;
  logic hold_ask = 1'b0;
  int hold_left = 0;
  int stuck = 0;
  int errors = 0;
  int bytes_sent = 0;
  int frames_expected = 0;
  int frames_seen = 0;
  int cfg_writes = 0;

  serial_can_frame_deframer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report($sformatf("frame %0d %s: got %h, expected %h", frames_seen, name, got, want));
    end
  endtask

  // Advance the mirror by one byte; done marks a completed frame
  task automatic step_deframer(input logic [7:0] b, output logic done, output frame_t fr);
    logic data_end;
    done = 1'b0;
    data_end = 1'b0;
    fr = '0;
    case (ph)
      HUNT_FIRST: begin
        if (b == hdr_first) ph = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        // a repeat of the first marker keeps waiting for the second
        if (b == hdr_second) ph = GET_ID_HI;
        else if (b != hdr_first) ph = HUNT_FIRST;
      end
      GET_ID_HI: begin
        id_acc = {b, 8'h00};
        ph = GET_ID_LO;
      end
      GET_ID_LO: begin
        id_acc[7:0] = b;
        ph = GET_LEN;
      end
      GET_LEN: begin
        cnt = '0;
        if (b > DEF_MAX_DATA_BYTES) begin
          ph = HUNT_FIRST;
        end else begin
          len_acc = b[3:0];
          if (len_acc == 4'd0) data_end = 1'b1;
          else ph = GET_DATA;
        end
      end
      GET_DATA: begin
        store[cnt[2:0]] = b;
        cnt = cnt + 4'd1;
        data_end = (cnt >= len_acc);
      end
      SKIP_TRAILER: begin
        cnt = cnt + 4'd1;
        done = (cnt >= TRAILER_BYTES);
      end
      default: begin
        ph = HUNT_FIRST;
        cnt = '0;
      end
    endcase
    // data complete: on to the trailer, or straight out when there is none
    if (data_end) begin
      cnt = '0;
      if (TRAILER_BYTES == 0) done = 1'b1;
      else ph = SKIP_TRAILER;
    end
    if (done) begin
      fr.frame_id = id_acc;
      fr.data_len = len_acc;
      for (int k = 0; k < NUM_PAYLOAD; k++) begin
        fr.payload[k] = (k < len_acc) ? store[k] : 8'h00;
      end
      ph = HUNT_FIRST;
      cnt = '0;
    end
  endtask

  // Offer one byte; on acceptance queue the frame it completes, if any
  task automatic push_byte(input logic [7:0] b, input logic use_row, input frame_t row_frame);
    logic done;
    frame_t fr;
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    step_deframer(b, done, fr);
    if (use_row) begin
      frame_q.push_back(row_frame);
      frames_expected++;
    end else if (done) begin
      frame_q.push_back(fr);
      frames_expected++;
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      CFG_HEADER_FIRST:  hdr_first = val;
      CFG_HEADER_SECOND: hdr_second = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, let every expected frame out, then let the pipeline settle
  task automatic settle_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed frames with random content, some noise and cut-short frames
  task automatic random_burst();
    logic [7:0] seq [$];
    logic [7:0] len_byte;
    int pick;
    int cut;
    pick = $urandom_range(0, 99);
    repeat ($urandom_range(0, 2)) seq.push_back(noise_byte());
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) seq.push_back(noise_byte());
    end else begin
      seq.push_back(hdr_first);
      if ($urandom_range(0, 9) == 0) seq.push_back(hdr_first);
      seq.push_back(hdr_second);
      seq.push_back(noise_byte());
      seq.push_back(noise_byte());
      if ($urandom_range(0, 99) < 12) len_byte = 8'($urandom_range(DEF_MAX_DATA_BYTES + 1, 255));
      else len_byte = 8'($urandom_range(0, DEF_MAX_DATA_BYTES));
      seq.push_back(len_byte);
      if (len_byte <= DEF_MAX_DATA_BYTES) begin
        repeat (len_byte) seq.push_back(noise_byte());
        repeat (TRAILER_BYTES) seq.push_back(noise_byte());
      end
      // broken frame: cut short, so the following bytes run on into it
      if (pick < 18) begin
        cut = $urandom_range(1, seq.size() - 1);
        while (seq.size() > cut) void'(seq.pop_back());
      end
    end
    foreach (seq[i]) push_byte(seq[i], 1'b0, '0);
  endtask

  // Output side: random back-pressure, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Compare each accepted frame with the oldest expected one
  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OUT_BITS-1:0];
      frames_seen++;
      if (frame_q.size() == 0) begin
        report($sformatf("frame %0d arrived with none expected", frames_seen));
      end else begin
        want = frame_q.pop_front();
        check_field("frame_id", got.frame_id, want.frame_id);
        check_field("data_len", got.data_len, want.data_len);
        for (int k = 0; k < NUM_PAYLOAD; k++) begin
          check_field($sformatf("payload%0d", k), got.payload[k], want.payload[k]);
        end
        check_field("pad", m_tdata[OUT_W-1:OUT_BITS], '0);
      end
    end
  end

  // Watchdog: too long without any request moving
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck == STUCK_LIMIT) begin
      $display("Timeout: no request accepted for %0d cycles", STUCK_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    frame_t row_frame;
    int seg_bytes;
    int seg_frames;
    hdr_first  = HEADER_FIRST_RST;
    hdr_second = HEADER_SECOND_RST;
    ph = HUNT_FIRST;
    cnt = '0;
    id_acc = '0;
    len_acc = '0;
    foreach (store[k]) store[k] = 8'h00;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part
    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) begin
        settle_idle();
        write_reg(row.idx, row.val);
      end else begin
        row_frame.frame_id = row.exp_id;
        row_frame.data_len = row.exp_len;
        row_frame.payload  = row.exp_payload;
        push_byte(row.val, row.typed, row_frame);
      end
    end

    // Random part: a marker setting and an idle mix per segment
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      settle_idle();
      snd_idle = (seg < 2) ? 9 : (seg < 4) ? 49 : 0;
      rcv_idle = (seg < 2) ? 49 : (seg < 4) ? 9 : 0;
      case (seg)
        1: begin
          write_reg(CFG_HEADER_FIRST, 8'h00);
          write_reg(CFG_HEADER_SECOND, 8'h00);
        end
        2: begin
          write_reg(CFG_HEADER_FIRST, 8'hFF);
          write_reg(CFG_HEADER_SECOND, 8'hFF);
        end
        3: begin
          write_reg(CFG_HEADER_FIRST, 8'($urandom_range(0, 255)));
          write_reg(CFG_HEADER_SECOND, 8'($urandom_range(0, 255)));
          write_reg(CFG_SPARE_B, 8'($urandom_range(0, 255)));
        end
        4: begin
          write_reg(CFG_HEADER_FIRST, 8'h00);
          write_reg(CFG_HEADER_SECOND, 8'hFF);
        end
        5: begin
          write_reg(CFG_HEADER_FIRST, HEADER_FIRST_RST);
          write_reg(CFG_HEADER_SECOND, HEADER_SECOND_RST);
        end
        default: ;
      endcase
      // last segment: hold the output off while bytes keep coming
      if (seg == NUM_SEGS - 1) begin
        @(posedge clk);
        hold_ask = 1'b1;
      end
      seg_bytes  = bytes_sent;
      seg_frames = frames_expected;
      while (bytes_sent - seg_bytes < SEG_BYTES || frames_expected - seg_frames < SEG_FRAMES) begin
        random_burst();
      end
    end

    settle_idle();
    if (frame_q.size() != 0) begin
      report($sformatf("%0d expected frames never arrived", frame_q.size()));
    end

    $display("Sent %0d serial bytes, checked %0d frames, %0d register writes.",
             bytes_sent, frames_seen, cfg_writes);
    $display("Covered six marker settings, mixed back-pressure and a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
sv/scd_pkg.sv
sv/scd_parser.sv
sv/serial_can_frame_deframer.sv
sim/tb_top.sv
